// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the vertical flight plant
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/vfps_pkg.sv
// shared types and codes of the vertical flight plant step block
// no dependencies
package vfps_pkg;

  localparam int ELAPSED_W = 32;
  localparam int REG_IDX_W = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_GRAVITY     = 3'd0;
  localparam reg_idx_t REG_STEP_DT     = 3'd1;
  localparam reg_idx_t REG_CRASH_LIMIT = 3'd2;
  localparam reg_idx_t REG_THRUST_MIN  = 3'd3;
  localparam reg_idx_t REG_THRUST_MAX  = 3'd4;

  localparam logic OP_SET_THRUST = 1'b0;
  localparam logic OP_ADVANCE    = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SOFT  = 2'd1,
    EV_CRASH = 2'd2
  } tdown_t;

endpackage

// File: hw/rtl/vertical_flight_plant_step.sv
// vertical flight plant step: euler integrator of height and speed with ground contact
// depends on vfps_pkg and assert_macros.svh
//
// usage
//   input channel (in_valid / in_stall) carries operation and thrust; one transfer is one
//   item. operation set-thrust clips the command and stores the thrust acceleration,
//   operation advance integrates one time step. every item gives exactly one result
//   transfer on the output channel (out_valid / out_stall).
//   a new input transfer is taken only after the previous item has reached the output
//   register; in_stall is high while an item is worked on. an advance makes three
//   multiplies through the one shared multiplier (a*dt, speed*dt, adt*dt).
//   a result stalled by the receiver waits in the output register; the next item is taken
//   meanwhile and holds in its last step until the output register is free.
//   configuration goes through the apb port; it must be written only while the block is
//   idle, and the block itself does not enforce this.
//   rst (synchronous) clears height, speed, stored acceleration, crash flag and time,
//   and loads the default gravity, time step, crash limit and thrust limits.
`include "assert_macros.svh"

module vertical_flight_plant_step #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32,
  parameter int PDATA_W    = (WORD_WIDTH > 32) ? 64 : 32,
  parameter int ADDR_W     = (WORD_WIDTH > 32) ? 6 : 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic signed [FRAC_BITS+2:0]        thrust,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [WORD_WIDTH-1:0]       height_out,
  output logic signed [WORD_WIDTH-1:0]       speed_out,
  output logic [vfps_pkg::ELAPSED_W-1:0]     elapsed_time,
  output logic                               crashed_flag,
  output vfps_pkg::tdown_t                   touchdown_event,
  output logic                               thrust_clipped,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ADDR_W-1:0]                  paddr,
  input  logic [PDATA_W-1:0]                 pwdata,
  output logic [PDATA_W-1:0]                 prdata,
  output logic                               pready
);
  import vfps_pkg::*;

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int THW   = F + 3;
  localparam int DTW   = F + 1;
  localparam int TW    = W + 1;
  localparam int AW    = W + 2;
  localparam int BW    = F + 3;
  localparam int PW    = AW + BW;
  localparam int XW    = W + 4;
  localparam int ADDR_LSB = (WORD_WIDTH > 32) ? 3 : 2;

  localparam logic signed [W-1:0]   GRAV_RST  = W'((-64'sd642908 <<< F) >>> 16);
  localparam logic [DTW-1:0]        DT_RST    = DTW'((64'd655 << F) >> 16);
  localparam logic signed [W-1:0]   CRASH_RST = W'(-(64'sd1 <<< (F - 1)));
  localparam logic signed [THW-1:0] TMIN_RST  = THW'(-(64'sd1 <<< F));
  localparam logic signed [THW-1:0] TMAX_RST  = THW'(64'sd1 <<< F);
  localparam logic signed [XW-1:0]  SAT_HI    = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0]  SAT_LO    = ~SAT_HI;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_M1, S_TH, S_M2, S_M3, S_M4, S_UPD
  } state_t;

  state_t state;
  logic   done_wait;
  logic   out_load;

  // configuration
  logic signed [W-1:0]   gravity;
  logic [DTW-1:0]        step_dt;
  logic signed [W-1:0]   crash_limit;
  logic signed [THW-1:0] thrust_min;
  logic signed [THW-1:0] thrust_max;

  // plant state
  logic signed [W-1:0]     height;
  logic signed [W-1:0]     speed;
  logic signed [W-1:0]     stored_accel;
  logic                    crashed;
  logic [ELAPSED_W-1:0]    elapsed;

  // working registers
  logic                    op_q;
  logic signed [THW-1:0]   thrust_q;
  logic signed [THW-1:0]   tclip;
  logic                    clip_q;
  tdown_t                  event_q;
  logic signed [TW-1:0]    tmp;
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    adt;
  logic signed [XW-1:0]    hsum;

  logic signed [AW-1:0]    mul_a;
  logic signed [BW-1:0]    mul_b;
  logic signed [BW-1:0]    dt_ext;
  logic signed [PW-1:0]    prod_sh1;
  logic signed [PW-1:0]    prod_sh2;
  logic signed [THW-1:0]   t_lo;
  logic signed [THW-1:0]   t_clip_next;
  logic                    clip_next;
  logic signed [W-1:0]     h_new;
  logic signed [W-1:0]     s_new;
  logic signed [W-1:0]     acc_new;
  logic                    wr_en;
  reg_idx_t                reg_idx;

  function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
    logic signed [W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign reg_idx  = reg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
  assign dt_ext   = signed'(BW'(step_dt));
  assign done_wait = out_valid && out_stall;
  assign out_load  = (state == S_UPD) && !done_wait;

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      S_M1: begin
        mul_a = AW'(tmp);
        mul_b = (op_q == OP_ADVANCE) ? dt_ext : BW'(tclip);
      end
      S_M2: begin
        mul_a = AW'(speed);
        mul_b = dt_ext;
      end
      S_M3: begin
        mul_a = adt;
        mul_b = dt_ext;
      end
      default: begin
        mul_a = AW'(tmp);
        mul_b = dt_ext;
      end
    endcase
  end

  assign prod_sh1 = prod >>> F;
  assign prod_sh2 = prod >>> (F + 1);

  // thrust clip: raise to the minimum first, then lower to the maximum
  always_comb begin
    t_lo        = (thrust_q < thrust_min) ? thrust_min : thrust_q;
    t_clip_next = (t_lo > thrust_max) ? thrust_max : t_lo;
    clip_next   = (thrust_q < thrust_min) || (t_lo > thrust_max);
  end

  assign h_new   = sat_w(hsum + XW'(prod_sh2));
  assign s_new   = sat_w(XW'(speed) + XW'(adt));
  assign acc_new = sat_w(XW'(prod_sh1) - XW'(gravity));

  always_comb begin
    unique case (reg_idx)
      REG_GRAVITY:     prdata = PDATA_W'(gravity);
      REG_STEP_DT:     prdata = PDATA_W'(step_dt);
      REG_CRASH_LIMIT: prdata = PDATA_W'(crash_limit);
      REG_THRUST_MIN:  prdata = PDATA_W'(thrust_min);
      REG_THRUST_MAX:  prdata = PDATA_W'(thrust_max);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      gravity      <= GRAV_RST;
      step_dt      <= DT_RST;
      crash_limit  <= CRASH_RST;
      thrust_min   <= TMIN_RST;
      thrust_max   <= TMAX_RST;
      height       <= '0;
      speed        <= '0;
      stored_accel <= '0;
      crashed      <= 1'b0;
      elapsed      <= '0;
    end else begin
      if (wr_en) begin
        unique case (reg_idx)
          REG_GRAVITY:     gravity     <= pwdata[W-1:0];
          REG_STEP_DT:     step_dt     <= pwdata[DTW-1:0];
          REG_CRASH_LIMIT: crash_limit <= pwdata[W-1:0];
          REG_THRUST_MIN:  thrust_min  <= pwdata[THW-1:0];
          REG_THRUST_MAX:  thrust_max  <= pwdata[THW-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= operation;
            thrust_q <= thrust;
            state    <= S_ACC;
          end
        end
        S_ACC: begin
          event_q <= EV_NONE;
          if (op_q == OP_SET_THRUST) begin
            tmp    <= -TW'(gravity);
            tclip  <= t_clip_next;
            clip_q <= clip_next;
            state  <= S_M1;
          end else if (crashed) begin
            clip_q  <= 1'b0;
            elapsed <= elapsed + ELAPSED_W'(step_dt);
            state   <= S_UPD;
          end else begin
            tmp    <= TW'(stored_accel) + TW'(gravity);
            clip_q <= 1'b0;
            state  <= S_M1;
          end
        end
        S_M1: begin
          state <= (op_q == OP_ADVANCE) ? S_M2 : S_TH;
        end
        S_TH: begin
          stored_accel <= acc_new;
          state        <= S_UPD;
        end
        S_M2: begin
          adt   <= prod_sh1[AW-1:0];
          state <= S_M3;
        end
        S_M3: begin
          hsum  <= XW'(height) + XW'(prod_sh1);
          state <= S_M4;
        end
        S_M4: begin
          elapsed <= elapsed + ELAPSED_W'(step_dt);
          state   <= S_UPD;
          // ground contact
          if (h_new[W-1] || (h_new == '0)) begin
            if (!height[W-1] && (height != '0)) begin
              if (s_new < crash_limit) begin
                crashed <= 1'b1;
                event_q <= EV_CRASH;
              end else begin
                event_q <= EV_SOFT;
              end
            end
            height <= '0;
            speed  <= '0;
          end else begin
            height <= h_new;
            speed  <= s_new;
          end
        end
        S_UPD: begin
          if (out_load) begin
            height_out      <= height;
            speed_out       <= speed;
            elapsed_time    <= elapsed;
            crashed_flag    <= crashed;
            touchdown_event <= event_q;
            thrust_clipped  <= clip_q;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_crash_latched, clk, rst, out_valid && (touchdown_event == EV_CRASH), crashed_flag, "crash event without crash flag")
  `ASSERT_IMPLY(a_ground_zero, clk, rst, out_valid && (touchdown_event != EV_NONE), (height_out == '0) && (speed_out == '0), "touchdown with nonzero motion")
  `ASSERT_IMPLY(a_clip_no_event, clk, rst, out_valid && thrust_clipped, touchdown_event == EV_NONE, "clipped thrust on an advance result")
  `ASSERT_ALWAYS(a_height_nonneg, clk, rst, !height[WORD_WIDTH-1], "height below ground")

endmodule

// File: tb/vertical_flight_plant_step_tb.sv
`timescale 1ns / 100ps
// testbench of vertical_flight_plant_step: directed and random transfers, every result
// checked against a fixed-point predictor of height, speed, time and ground contact
// depends on vfps_pkg and the vertical_flight_plant_step rtl
module vertical_flight_plant_step_tb;
  import vfps_pkg::*;

  localparam int FRAC = 16;
  localparam int TW = FRAC + 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 160;
  localparam reg_idx_t REG_UNUSED = 3'd5;
  localparam longint GRAVITY_DEF = -642908;
  localparam longint DT_DEF = 655;
  localparam longint CRASH_DEF = -32768;
  localparam longint WORD_MAX = (64'sd1 << 31) - 1;
  localparam longint WORD_MIN = -(64'sd1 << 31);
  localparam longint TH_LIM = 131072;
  localparam longint ONE_G = 65536;
  localparam longint ONE_SEC = 65536;

  typedef struct {
    logic signed [31:0] height;
    logic signed [31:0] speed;
    logic [31:0]        elapsed;
    logic               crashed;
    tdown_t             tdown;
    logic               clipped;
  } plant_obs_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic operation;
  logic signed [TW-1:0] thrust;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] height_out;
  logic signed [31:0] speed_out;
  logic [31:0] elapsed_time;
  logic crashed_flag;
  tdown_t touchdown_event;
  logic thrust_clipped;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  longint cfg_gravity, cfg_dt, cfg_crash, cfg_tmin, cfg_tmax;
  longint plant_height, plant_speed, plant_accel;
  logic plant_crashed;
  logic [31:0] plant_clock;

  plant_obs_t pending_plant_states[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  vertical_flight_plant_step dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint fx_mul_floor(longint x, longint y, int s);
    longint lo;
    lo = x & ((64'sd1 << s) - 1);
    return (x >>> s) * y + ((lo * y) >>> s);
  endfunction

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic plant_obs_t predict_plant_item(logic op, logic signed [TW-1:0] thr);
    plant_obs_t obs;
    longint cmd, adt, dh_v, dh_a, prev_height;
    obs.tdown = EV_NONE;
    obs.clipped = 1'b0;
    if (op == OP_SET_THRUST) begin
      cmd = thr;
      if (cmd < cfg_tmin) begin
        cmd = cfg_tmin;
        obs.clipped = 1'b1;
      end
      if (cmd > cfg_tmax) begin
        cmd = cfg_tmax;
        obs.clipped = 1'b1;
      end
      plant_accel = sat_word(fx_mul_floor(-cfg_gravity, cmd, FRAC) - cfg_gravity);
    end else begin
      if (!plant_crashed) begin
        prev_height = plant_height;
        adt = fx_mul_floor(plant_accel + cfg_gravity, cfg_dt, FRAC);
        dh_v = fx_mul_floor(plant_speed, cfg_dt, FRAC);
        dh_a = fx_mul_floor(adt, cfg_dt, FRAC + 1);
        plant_height = sat_word(plant_height + dh_v + dh_a);
        plant_speed = sat_word(plant_speed + adt);
        if (plant_height <= 0) begin
          if (prev_height > 0) begin
            if (plant_speed < cfg_crash) begin
              plant_crashed = 1'b1;
              obs.tdown = EV_CRASH;
            end else begin
              obs.tdown = EV_SOFT;
            end
          end
          plant_height = 0;
          plant_speed = 0;
        end
      end
      plant_clock = plant_clock + cfg_dt[31:0];
    end
    obs.height = plant_height[31:0];
    obs.speed = plant_speed[31:0];
    obs.elapsed = plant_clock;
    obs.crashed = plant_crashed;
    return obs;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint random_thrust();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return longint'(signed'(TW'($urandom)));
    if (r < 4) return longint'($urandom_range(0, 8192)) - 4096;
    return longint'($urandom_range(0, 2 * TH_LIM)) - TH_LIM;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch %s: expected %0d, got %0d at %0t", name, want, got, $time);
    end
  endtask

  always @(posedge clk) begin : result_check
    plant_obs_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_plant_states.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result transfer with nothing pending at %0t", $time);
      end else begin
        want = pending_plant_states.pop_front();
        check_field("height_out", want.height, height_out);
        check_field("speed_out", want.speed, speed_out);
        check_field("elapsed_time", want.elapsed, elapsed_time);
        check_field("crashed_flag", want.crashed, crashed_flag);
        check_field("touchdown_event", want.tdown, touchdown_event);
        check_field("thrust_clipped", want.clipped, thrust_clipped);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || steady) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) stall_left = pick_gap();
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(logic op, logic signed [TW-1:0] thr);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    thrust <= thr;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_plant_states.push_back(predict_plant_item(op, thr));
  endtask

  task automatic set_thrust(longint thr);
    send_item(OP_SET_THRUST, TW'(thr));
  endtask

  // thrust field carries noise on an advance
  task automatic advance_step();
    send_item(OP_ADVANCE, TW'($urandom));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_plant_states.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, longint value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value[31:0];
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_GRAVITY: cfg_gravity = longint'($signed(value[31:0]));
      REG_STEP_DT: cfg_dt = longint'(value[16:0]);
      REG_CRASH_LIMIT: cfg_crash = longint'($signed(value[31:0]));
      REG_THRUST_MIN: cfg_tmin = longint'($signed(value[18:0]));
      REG_THRUST_MAX: cfg_tmax = longint'($signed(value[18:0]));
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic pick_flight_config();
    longint g, dt, lo, hi, tmp;
    case ($urandom_range(0, 5))
      0: g = GRAVITY_DEF;
      1: g = WORD_MIN;
      2: g = WORD_MAX;
      3: g = longint'($signed($urandom));
      default: g = -longint'($urandom_range(0, 1 << 21));
    endcase
    case ($urandom_range(0, 7))
      0: dt = 0;
      1: dt = 1;
      2: dt = ONE_SEC;
      3: dt = DT_DEF;
      default: dt = $urandom_range(1, 65536);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      lo = -TH_LIM;
      hi = TH_LIM;
    end else begin
      lo = longint'($urandom_range(0, 2 * TH_LIM)) - TH_LIM;
      hi = longint'($urandom_range(0, 2 * TH_LIM)) - TH_LIM;
      if (lo > hi && $urandom_range(0, 7) != 0) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
    end
    write_reg(REG_GRAVITY, g);
    write_reg(REG_STEP_DT, dt);
    write_reg(REG_THRUST_MIN, lo);
    write_reg(REG_THRUST_MAX, hi);
  endtask

  task automatic test_power_on_defaults();
    advance_step();
    advance_step();
    set_thrust(0);
    set_thrust(98304);
    set_thrust(19'sh3FFFF);
    set_thrust(19'sh40000);
    set_thrust(-ONE_G);
    advance_step();
    settle();
    write_reg(REG_UNUSED, longint'($urandom));
    set_thrust(ONE_G);
    advance_step();
  endtask

  task automatic test_thrust_clipping();
    settle();
    write_reg(REG_THRUST_MIN, TH_LIM);
    write_reg(REG_THRUST_MAX, -TH_LIM);
    set_thrust(0);
    set_thrust(-TH_LIM);
    set_thrust(TH_LIM);
    settle();
    write_reg(REG_THRUST_MIN, -TH_LIM);
    write_reg(REG_THRUST_MAX, TH_LIM);
    set_thrust(-TH_LIM);
    set_thrust(TH_LIM);
  endtask

  task automatic test_climb_and_soft_landing();
    settle();
    write_reg(REG_CRASH_LIMIT, WORD_MIN);
    write_reg(REG_STEP_DT, ONE_SEC);
    set_thrust(ONE_G);
    advance_step();
    set_thrust(-ONE_G);
    repeat (3) advance_step();
    set_thrust(ONE_G);
    advance_step();
    settle();
    // motion frozen with a zero step, time does not move either
    write_reg(REG_STEP_DT, 0);
    advance_step();
    advance_step();
  endtask

  task automatic test_gravity_extremes();
    settle();
    write_reg(REG_STEP_DT, ONE_SEC);
    write_reg(REG_GRAVITY, WORD_MAX);
    set_thrust(TH_LIM);
    advance_step();
    settle();
    write_reg(REG_GRAVITY, WORD_MIN);
    set_thrust(-TH_LIM);
    advance_step();
    advance_step();
  endtask

  task automatic test_random_flight();
    int sent, run;
    repeat (RANDOM_PHASES) begin
      settle();
      pick_flight_config();
      steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        set_thrust(random_thrust());
        run = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
        repeat (run) advance_step();
        sent += run + 1;
      end
      steady = 1'b0;
    end
  endtask

  task automatic test_crash_latch();
    int tries;
    settle();
    write_reg(REG_GRAVITY, GRAVITY_DEF);
    write_reg(REG_STEP_DT, ONE_SEC);
    write_reg(REG_CRASH_LIMIT, 0);
    write_reg(REG_THRUST_MIN, -TH_LIM);
    write_reg(REG_THRUST_MAX, TH_LIM);
    set_thrust(TH_LIM);
    advance_step();
    advance_step();
    settle();
    write_reg(REG_GRAVITY, WORD_MIN);
    set_thrust(-TH_LIM);
    tries = 0;
    while (!plant_crashed && tries < 20) begin
      advance_step();
      tries++;
    end
    settle();
    write_reg(REG_STEP_DT, longint'($urandom_range(1, 65536)));
    write_reg(REG_GRAVITY, GRAVITY_DEF);
    repeat (40) begin
      if ($urandom_range(0, 2) == 0) set_thrust(random_thrust());
      else advance_step();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_SET_THRUST;
    thrust = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_gravity = GRAVITY_DEF;
    cfg_dt = DT_DEF;
    cfg_crash = CRASH_DEF;
    cfg_tmin = -ONE_G;
    cfg_tmax = ONE_G;
    plant_height = 0;
    plant_speed = 0;
    plant_accel = 0;
    plant_crashed = 1'b0;
    plant_clock = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_power_on_defaults();
    test_thrust_clipping();
    test_climb_and_soft_landing();
    test_gravity_extremes();
    test_random_flight();
    test_crash_latch();
    settle();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
